### hw/rtl/fet_pkg.sv
// fet_pkg: shared widths, register indexes, mode codes, controller states
// and the command/status structs of the escape-time fractal unit.
// No dependencies.
package fet_pkg;

   // coordinate format, signed Q4.28
   localparam int COORD_BITS = 32;
   localparam int FRAC_BITS  = 28;
   localparam int ITER_BITS  = 16;
   localparam int PIXEL_BITS = 12;
   localparam int SHADE_BITS = 8;

   // exact products and the wide sums built from them
   localparam int PROD_BITS  = 2 * COORD_BITS;
   localparam int WIDE_BITS  = 2 * COORD_BITS + 2;

   // shade divider: k*255 fits in these bits
   localparam int NUM_BITS   = ITER_BITS + SHADE_BITS;

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRACTAL_MODE = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_ITER     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONST_REAL   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONST_IMAG   = 3'd3;

   // fractal variants
   localparam logic [1:0] MODE_MANDELBROT = 2'd0;
   localparam logic [1:0] MODE_JULIA      = 2'd1;
   localparam logic [1:0] MODE_SHIP       = 2'd2;
   localparam logic [1:0] MODE_SHIP_CONST = 2'd3;

   localparam logic [ITER_BITS-1:0] MAX_ITER_RESET = 16'd64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_TEST,
      ST_DIV,
      ST_FINISH
   } fet_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic mult;
      logic test;
      logic div_start;
      logic div_step;
      logic out_load;
   } fet_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cont;
      logic scale;
      logic div_last;
   } fet_status_type;

endpackage

### hw/rtl/fractal_escape_time_unit.sv
// Escape-time fractal unit (Mandelbrot, Julia, Burning Ship). One pixel is
// taken at a time; each orbit iteration is a product stage, then the escape
// test and z update. When the orbit escaped and max_iter is nonzero, the
// bit-serial shade divider runs before the result is loaded. The result sits
// in an output register, so the next pixel is accepted while the previous
// beat waits; a finished pixel is held until that beat is taken.
// Registers: 0 fractal_mode, 1 max_iter, 2 const_real, 3 const_imag; write
// them only while idle.
// Depends on fet_pkg, fet_ctrl, fet_datapath.
module fractal_escape_time_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // pixel request
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [fet_pkg::COORD_BITS-1:0] req_point_real,
   input  logic signed [fet_pkg::COORD_BITS-1:0] req_point_imag,
   input  logic [fet_pkg::PIXEL_BITS-1:0]        req_pixel_col,
   input  logic [fet_pkg::PIXEL_BITS-1:0]        req_pixel_row,
   // pixel result
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_escaped,
   output logic [fet_pkg::SHADE_BITS-1:0]        rsp_shade,
   output logic [fet_pkg::PIXEL_BITS-1:0]        rsp_out_col,
   output logic [fet_pkg::PIXEL_BITS-1:0]        rsp_out_row,
   // register writes
   input  logic                                  csr_wr_en,
   input  logic [fet_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [fet_pkg::CSR_DATA_BITS-1:0]     csr_wr_data
);
   import fet_pkg::*;

   fet_cmd_type    cmd;
   fet_status_type status;

   // sequencer
   fet_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and storage
   fet_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .req_point_real (req_point_real),
      .req_point_imag (req_point_imag),
      .req_pixel_col  (req_pixel_col),
      .req_pixel_row  (req_pixel_row),
      .rsp_escaped    (rsp_escaped),
      .rsp_shade      (rsp_shade),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row)
   );

endmodule

### hw/rtl/fet_shade_div.sv
// fet_shade_div: restoring divider for the shade, floor(k*255/max_iter),
// one quotient bit per cycle while step is high, msb first. Depends on fet_pkg.
module fet_shade_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           step,
   input  logic [fet_pkg::ITER_BITS-1:0]  count,
   input  logic [fet_pkg::ITER_BITS-1:0]  divisor,
   output logic [fet_pkg::SHADE_BITS-1:0] quotient,
   output logic                           last
);
   import fet_pkg::*;

   localparam int STEP_BITS = $clog2(SHADE_BITS);

   logic [NUM_BITS-1:0]   rem_ff, rem_in;
   logic [NUM_BITS-2:0]   div_ff, div_in;
   logic [SHADE_BITS-1:0] quo_ff, quo_in;
   logic [STEP_BITS-1:0]  cnt_ff, cnt_in;
   logic                  fits;

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   // k*255 as (k << 8) - k, divisor aligned to the top quotient bit
   always_comb begin
      fits   = rem_ff >= {1'b0, div_ff};
      rem_in = rem_ff;
      div_in = div_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = {count, SHADE_BITS'(0)} - NUM_BITS'(count);
         div_in = {divisor, (SHADE_BITS-1)'(0)};
         quo_in = '0;
         cnt_in = STEP_BITS'(SHADE_BITS - 1);
      end else if (step) begin
         if (fits) begin
            rem_in = rem_ff - {1'b0, div_ff};
         end
         div_in = div_ff >> 1;
         quo_in = {quo_ff[SHADE_BITS-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   assign quotient = quo_ff;
   assign last     = cnt_ff == '0;

endmodule

### hw/rtl/fet_datapath.sv
// fet_datapath: configuration registers, orbit registers, the three
// products, escape test, z update with saturation and the result register.
// Depends on fet_pkg and fet_shade_div.
module fet_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  fet_pkg::fet_cmd_type                cmd,
   output fet_pkg::fet_status_type             status,
   input  logic                                csr_wr_en,
   input  logic [fet_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [fet_pkg::CSR_DATA_BITS-1:0]   csr_wr_data,
   input  logic signed [fet_pkg::COORD_BITS-1:0] req_point_real,
   input  logic signed [fet_pkg::COORD_BITS-1:0] req_point_imag,
   input  logic [fet_pkg::PIXEL_BITS-1:0]      req_pixel_col,
   input  logic [fet_pkg::PIXEL_BITS-1:0]      req_pixel_row,
   output logic                                rsp_escaped,
   output logic [fet_pkg::SHADE_BITS-1:0]      rsp_shade,
   output logic [fet_pkg::PIXEL_BITS-1:0]      rsp_out_col,
   output logic [fet_pkg::PIXEL_BITS-1:0]      rsp_out_row
);
   import fet_pkg::*;

   localparam logic [PROD_BITS-1:0] ESC_LIMIT = PROD_BITS'(1) << (2 * FRAC_BITS + 2);

   // clamp a wide sum to the signed coordinate range
   function automatic logic signed [COORD_BITS-1:0] sat_coord(
      input logic signed [WIDE_BITS-1:0] v
   );
      logic signed [WIDE_BITS-1:0] hi;
      logic signed [WIDE_BITS-1:0] lo;
      hi = WIDE_BITS'({1'b0, {(COORD_BITS-1){1'b1}}});
      lo = -hi - WIDE_BITS'(1);
      if (v > hi) begin
         sat_coord = {1'b0, {(COORD_BITS-1){1'b1}}};
      end else if (v < lo) begin
         sat_coord = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
         sat_coord = v[COORD_BITS-1:0];
      end
   endfunction

   // configuration
   logic [1:0]                   mode_ff, mode_in;
   logic [ITER_BITS-1:0]         max_iter_ff, max_iter_in;
   logic signed [COORD_BITS-1:0] const_re_ff, const_re_in;
   logic signed [COORD_BITS-1:0] const_im_ff, const_im_in;

   // per-pixel working registers
   logic signed [COORD_BITS-1:0] zr_ff, zr_in;
   logic signed [COORD_BITS-1:0] zi_ff, zi_in;
   logic signed [COORD_BITS-1:0] cr_ff, cr_in;
   logic signed [COORD_BITS-1:0] ci_ff, ci_in;
   logic [PIXEL_BITS-1:0]        col_ff, col_in;
   logic [PIXEL_BITS-1:0]        row_ff, row_in;
   logic [ITER_BITS-1:0]         k_ff, k_in;
   logic signed [PROD_BITS-1:0]  sq_re_ff, sq_re_in;
   logic signed [PROD_BITS-1:0]  sq_im_ff, sq_im_in;
   logic signed [PROD_BITS-1:0]  cross_ff, cross_in;
   logic                         esc_ff, esc_in;
   logic                         shade_sel_ff, shade_sel_in;

   // result register
   logic                  out_esc_ff, out_esc_in;
   logic [SHADE_BITS-1:0] out_shade_ff, out_shade_in;
   logic [PIXEL_BITS-1:0] out_col_ff, out_col_in;
   logic [PIXEL_BITS-1:0] out_row_ff, out_row_in;

   logic                        use_const;
   logic                        ship;
   logic [PROD_BITS-1:0]        mag2;
   logic                        over;
   logic                        reached;
   logic                        cont;
   logic                        scale;
   logic                        div_last;
   logic signed [WIDE_BITS-1:0] diff_w;
   logic signed [WIDE_BITS-1:0] cross_w;
   logic signed [WIDE_BITS-1:0] new_re_w;
   logic signed [WIDE_BITS-1:0] new_im_w;
   logic [SHADE_BITS-1:0]       quotient;

   // mode decode
   always_comb begin
      unique case (mode_ff) inside
         MODE_MANDELBROT: begin
            use_const = 1'b0;
            ship      = 1'b0;
         end
         MODE_JULIA: begin
            use_const = 1'b1;
            ship      = 1'b0;
         end
         MODE_SHIP: begin
            use_const = 1'b0;
            ship      = 1'b1;
         end
         default: begin
            use_const = 1'b1;
            ship      = 1'b1;
         end
      endcase
   end

   // register write decode
   always_comb begin
      mode_in     = mode_ff;
      max_iter_in = max_iter_ff;
      const_re_in = const_re_ff;
      const_im_in = const_im_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRACTAL_MODE: mode_in     = csr_wr_data[1:0];
            CSR_MAX_ITER:     max_iter_in = csr_wr_data[ITER_BITS-1:0];
            CSR_CONST_REAL:   const_re_in = csr_wr_data[COORD_BITS-1:0];
            CSR_CONST_IMAG:   const_im_in = csr_wr_data[COORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_MANDELBROT;
         max_iter_ff <= MAX_ITER_RESET;
         const_re_ff <= '0;
         const_im_ff <= '0;
      end else begin
         mode_ff     <= mode_in;
         max_iter_ff <= max_iter_in;
         const_re_ff <= const_re_in;
         const_im_ff <= const_im_in;
      end
   end

   // escape test on the registered squares
   always_comb begin
      mag2    = sq_re_ff + sq_im_ff;
      over    = mag2 > ESC_LIMIT;
      reached = mag2 >= ESC_LIMIT;
   end

   assign cont   = (k_ff < max_iter_ff) && !over;
   assign scale  = reached && (max_iter_ff != '0);
   assign status = '{cont: cont, scale: scale, div_last: div_last};

   // next z: floor shifts of the exact values, add c, saturate
   always_comb begin
      diff_w  = WIDE_BITS'(sq_re_ff) - WIDE_BITS'(sq_im_ff);
      cross_w = WIDE_BITS'(cross_ff);
      if (ship && cross_ff[PROD_BITS-1]) begin
         cross_w = -cross_w;
      end
      new_re_w = (diff_w >>> FRAC_BITS) + WIDE_BITS'(cr_ff);
      new_im_w = (cross_w >>> (FRAC_BITS - 1)) + WIDE_BITS'(ci_ff);
   end

   // working register updates
   always_comb begin
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      k_in         = k_ff;
      esc_in       = esc_ff;
      shade_sel_in = shade_sel_ff;
      // 32x32 signed products, operands sign-extended
      sq_re_in     = PROD_BITS'(zr_ff) * PROD_BITS'(zr_ff);
      sq_im_in     = PROD_BITS'(zi_ff) * PROD_BITS'(zi_ff);
      cross_in     = PROD_BITS'(zr_ff) * PROD_BITS'(zi_ff);
      if (cmd.load) begin
         zr_in  = req_point_real;
         zi_in  = req_point_imag;
         cr_in  = use_const ? const_re_ff : req_point_real;
         ci_in  = use_const ? const_im_ff : req_point_imag;
         col_in = req_pixel_col;
         row_in = req_pixel_row;
         k_in   = '0;
      end else if (cmd.test) begin
         if (cont) begin
            zr_in = sat_coord(new_re_w);
            zi_in = sat_coord(new_im_w);
            k_in  = k_ff + 1'b1;
         end else begin
            esc_in       = reached;
            shade_sel_in = scale;
         end
      end
   end

   always_ff @(posedge clock) begin
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      cr_ff        <= cr_in;
      ci_ff        <= ci_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      k_ff         <= k_in;
      esc_ff       <= esc_in;
      shade_sel_ff <= shade_sel_in;
      if (cmd.mult) begin
         sq_re_ff <= sq_re_in;
         sq_im_ff <= sq_im_in;
         cross_ff <= cross_in;
      end
   end

   // shade scaling
   fet_shade_div u_shade_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .step     (cmd.div_step),
      .count    (k_ff),
      .divisor  (max_iter_ff),
      .quotient (quotient),
      .last     (div_last)
   );

   // result register
   always_comb begin
      out_esc_in   = out_esc_ff;
      out_shade_in = out_shade_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      if (cmd.out_load) begin
         out_esc_in   = esc_ff;
         out_shade_in = shade_sel_ff ? quotient : '0;
         out_col_in   = col_ff;
         out_row_in   = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_esc_ff   <= out_esc_in;
      out_shade_ff <= out_shade_in;
      out_col_ff   <= out_col_in;
      out_row_ff   <= out_row_in;
   end

   assign rsp_escaped = out_esc_ff;
   assign rsp_shade   = out_shade_ff;
   assign rsp_out_col = out_col_ff;
   assign rsp_out_row = out_row_ff;

endmodule

### hw/rtl/fet_ctrl.sv
// fet_ctrl: sequencer for one pixel at a time and the result valid flag.
// Depends on fet_pkg.
module fet_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  fet_pkg::fet_status_type status,
   output fet_pkg::fet_cmd_type    cmd
);
   import fet_pkg::*;

   fet_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result register is free when empty or its beat leaves now
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            cmd.test = 1'b1;
            if (status.cont) begin
               state_in = ST_MULT;
            end else if (status.scale) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result valid
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### hw/rtl/fet_checker.sv
// fet_checker: port-level checks of the escape-time fractal unit and the
// bind that attaches them. Depends on fet_pkg and fractal_escape_time_unit.
module fet_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_escaped,
   input logic [fet_pkg::SHADE_BITS-1:0] rsp_shade
);
   import fet_pkg::*;

   // a pending result beat is held until taken
   hold_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped before it was taken");

   // one pixel at a time: busy right after an accept
   busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a pixel is in progress");

   // a bounded pixel carries no shade
   shade_only_escaped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_escaped |-> rsp_shade == '0)
      else $error("nonzero shade on a pixel that did not escape");

   // reset empties the result register
   reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind fractal_escape_time_unit fet_checker u_fet_checker (.*);

### bench/tb_fractal_escape_time_unit.sv
// tb_fractal_escape_time_unit: directed and random pixels through the escape-time
// fractal unit, each result checked against an orbit predictor held in this bench.
// Depends on fet_pkg and fractal_escape_time_unit.
module tb_fractal_escape_time_unit;
   import fet_pkg::*;

   // exact orbit arithmetic, wide enough for every product and sum
   localparam int CALC_BITS = 72;
   localparam logic signed [CALC_BITS-1:0] COORD_MAX = (72'sd1 <<< (COORD_BITS - 1)) - 72'sd1;
   localparam logic signed [CALC_BITS-1:0] COORD_MIN = -(72'sd1 <<< (COORD_BITS - 1));
   // |z|^2 == 4.0 at twice the fraction bits
   localparam logic signed [CALC_BITS-1:0] ESCAPE_RADIUS_SQ = 72'sd1 <<< (2 * FRAC_BITS + 2);
   localparam int unsigned SHADE_SCALE = (1 << SHADE_BITS) - 1;

   // Q4.28 points used by the directed pixels
   localparam logic signed [COORD_BITS-1:0] Q_MAX     = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_BITS-1:0] Q_MIN     = 32'sh8000_0000;
   localparam logic signed [COORD_BITS-1:0] Q_TWO     = 32'sh2000_0000;
   localparam logic signed [COORD_BITS-1:0] Q_ONE     = 32'sh1000_0000;
   localparam logic signed [COORD_BITS-1:0] Q_HALF    = 32'sh0800_0000;
   localparam logic signed [COORD_BITS-1:0] Q_QUARTER = 32'sh0400_0000;
   localparam logic signed [COORD_BITS-1:0] Q_CUSP    = 32'sh0428_F5C2;  // 0.26
   localparam logic signed [COORD_BITS-1:0] Q_TENTH   = 32'sh0199_999A;
   localparam logic signed [COORD_BITS-1:0] Q_SHIP_RE = -32'sh1C00_0000; // -1.75
   localparam logic signed [COORD_BITS-1:0] Q_SHIP_IM = -32'sh007A_E148; // -0.03
   localparam logic signed [COORD_BITS-1:0] Q_THREE_QTR = 32'sh0C00_0000;
   localparam int unsigned VIEW_SPAN  = 32'h2800_0000;                   // +-2.5
   localparam logic [PIXEL_BITS-1:0] PIXEL_LAST = '1;

   localparam int FIRST_UNUSED_CSR = CSR_CONST_IMAG + 1;
   localparam int LAST_CSR_INDEX   = (1 << CSR_INDEX_BITS) - 1;

   localparam int RANDOM_PHASES = 14;
   localparam int PHASE_PIXELS  = 100;
   localparam int TAIL_CYCLES   = 40;

   typedef struct {
      logic signed [COORD_BITS-1:0] re;
      logic signed [COORD_BITS-1:0] im;
      logic [PIXEL_BITS-1:0]        col;
      logic [PIXEL_BITS-1:0]        row;
   } pixel_req_type;

   typedef struct {
      logic                  escaped;
      logic [SHADE_BITS-1:0] shade;
      logic [PIXEL_BITS-1:0] col;
      logic [PIXEL_BITS-1:0] row;
   } pixel_res_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic signed [COORD_BITS-1:0]   req_point_real = '0;
   logic signed [COORD_BITS-1:0]   req_point_imag = '0;
   logic [PIXEL_BITS-1:0]          req_pixel_col = '0;
   logic [PIXEL_BITS-1:0]          req_pixel_row = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic                           rsp_escaped;
   logic [SHADE_BITS-1:0]          rsp_shade;
   logic [PIXEL_BITS-1:0]          rsp_out_col;
   logic [PIXEL_BITS-1:0]          rsp_out_row;
   logic                           csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0]      csr_index = '0;
   logic [CSR_DATA_BITS-1:0]       csr_wr_data = '0;

   // register copies as the unit should hold them
   logic [1:0]                   cfg_mode = MODE_MANDELBROT;
   logic [ITER_BITS-1:0]         cfg_max_iter = MAX_ITER_RESET;
   logic signed [COORD_BITS-1:0] cfg_c_re = '0;
   logic signed [COORD_BITS-1:0] cfg_c_im = '0;

   pixel_req_type staged_pixels[$];
   pixel_req_type pending_pixels[$];
   pixel_res_type predicted_shades[$];
   pixel_req_type cur_pixel;
   int  req_idle = 0;
   int  rsp_idle = 0;
   bit  steady = 1'b0;
   bit  mismatch_seen = 1'b0;

   fractal_escape_time_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_point_real (req_point_real),
      .req_point_imag (req_point_imag),
      .req_pixel_col  (req_pixel_col),
      .req_pixel_row  (req_pixel_row),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_escaped    (rsp_escaped),
      .rsp_shade      (rsp_shade),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // saturate to the signed coordinate range
   function automatic logic signed [CALC_BITS-1:0] clamp_coord(
      input logic signed [CALC_BITS-1:0] v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   // iterate the orbit of one pixel under the current register copies
   function automatic pixel_res_type escape_time(input pixel_req_type px);
      logic signed [CALC_BITS-1:0] zr, zi, cr, ci, rr, ii, ri;
      logic                        use_const, ship;
      int unsigned                 k;
      pixel_res_type               res;
      use_const = (cfg_mode == MODE_JULIA) || (cfg_mode == MODE_SHIP_CONST);
      ship = (cfg_mode == MODE_SHIP) || (cfg_mode == MODE_SHIP_CONST);
      zr = px.re;
      zi = px.im;
      cr = use_const ? cfg_c_re : px.re;
      ci = use_const ? cfg_c_im : px.im;
      rr = zr * zr;
      ii = zi * zi;
      k = 0;
      while (k < cfg_max_iter && rr + ii <= ESCAPE_RADIUS_SQ) begin
         ri = zr * zi;
         // burning ship folds the cross term positive
         if (ship && ri < 0) ri = -ri;
         zr = clamp_coord(((rr - ii) >>> FRAC_BITS) + cr);
         zi = clamp_coord((ri >>> (FRAC_BITS - 1)) + ci);
         rr = zr * zr;
         ii = zi * zi;
         k++;
      end
      res.escaped = (rr + ii >= ESCAPE_RADIUS_SQ);
      res.shade = (res.escaped && cfg_max_iter != 0) ?
                  SHADE_BITS'((k * SHADE_SCALE) / cfg_max_iter) : '0;
      res.col = px.col;
      res.row = px.row;
      return res;
   endfunction

   function automatic int draw_idle();
      if (steady) return 0;
      return ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 10));
   endfunction

   // random coordinate in +-span
   function automatic logic signed [COORD_BITS-1:0] rand_coord(input int unsigned span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   function automatic void queue_pixel(input logic signed [COORD_BITS-1:0] re, im,
                                       input logic [PIXEL_BITS-1:0] col, row);
      pixel_req_type px;
      px.re = re;
      px.im = im;
      px.col = col;
      px.row = row;
      staged_pixels.push_back(px);
   endfunction

   // mostly points near the sets, some anywhere in the coordinate range
   function automatic void queue_random_pixel();
      logic signed [COORD_BITS-1:0] re, im;
      re = ($urandom_range(0, 4) == 0) ? $urandom : rand_coord(VIEW_SPAN);
      im = ($urandom_range(0, 4) == 0) ? $urandom : rand_coord(VIEW_SPAN);
      queue_pixel(re, im, PIXEL_BITS'($urandom), PIXEL_BITS'($urandom));
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      case (idx)
         CSR_FRACTAL_MODE: cfg_mode = data[1:0];
         CSR_MAX_ITER:     cfg_max_iter = data[ITER_BITS-1:0];
         CSR_CONST_REAL:   cfg_c_re = data;
         CSR_CONST_IMAG:   cfg_c_im = data;
         default: ;
      endcase
   endtask

   // hand the staged pixels to the driver and wait until every result is back
   task automatic paint_staged();
      @(negedge clock);
      foreach (staged_pixels[i]) pending_pixels.push_back(staged_pixels[i]);
      staged_pixels.delete();
      do @(negedge clock);
      while (pending_pixels.size() != 0 || req_valid || predicted_shades.size() != 0);
   endtask

   // request side: present queued pixels, idle between beats
   always @(posedge clock) begin : drive_pixels
      logic holding;
      if (reset) begin
         req_valid <= 1'b0;
         req_idle = 0;
      end else begin
         holding = req_valid;
         if (req_valid && req_ready) begin
            predicted_shades.push_back(escape_time(cur_pixel));
            holding = 1'b0;
            req_idle = draw_idle();
         end
         if (!holding) begin
            if (req_idle != 0) begin
               req_idle--;
            end else if (pending_pixels.size() != 0) begin
               cur_pixel = pending_pixels.pop_front();
               req_point_real <= cur_pixel.re;
               req_point_imag <= cur_pixel.im;
               req_pixel_col  <= cur_pixel.col;
               req_pixel_row  <= cur_pixel.row;
               holding = 1'b1;
            end
         end
         req_valid <= holding;
      end
   end

   // result side: stall at random, compare each beat with the oldest prediction
   always @(posedge clock) begin : check_shades
      pixel_res_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_idle = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_shades.size() == 0) begin
               $error("result beat with no pixel outstanding: col %0d row %0d",
                      rsp_out_col, rsp_out_row);
               mismatch_seen = 1'b1;
            end else begin
               want = predicted_shades.pop_front();
               if (rsp_escaped !== want.escaped) begin
                  $error("escaped: expected %0d, got %0d", want.escaped, rsp_escaped);
                  mismatch_seen = 1'b1;
               end
               if (rsp_shade !== want.shade) begin
                  $error("shade: expected %0d, got %0d", want.shade, rsp_shade);
                  mismatch_seen = 1'b1;
               end
               if (rsp_out_col !== want.col) begin
                  $error("out_col: expected %0d, got %0d", want.col, rsp_out_col);
                  mismatch_seen = 1'b1;
               end
               if (rsp_out_row !== want.row) begin
                  $error("out_row: expected %0d, got %0d", want.row, rsp_out_row);
                  mismatch_seen = 1'b1;
               end
            end
            rsp_idle = draw_idle();
         end
         if (rsp_idle != 0) begin
            rsp_ready <= 1'b0;
            rsp_idle--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : run_phases
      logic [1:0]                   mode;
      logic [ITER_BITS-1:0]         limit;
      logic [CSR_DATA_BITS-1:0]     extra;
      int                           sel;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: origin, the circle itself, coordinate extremes
      queue_pixel('0, '0, '0, '0);
      queue_pixel(-Q_TWO, '0, PIXEL_LAST, PIXEL_LAST);  // orbit stays on |z| == 2
      queue_pixel(Q_TWO, '0, PIXEL_LAST, '0);
      queue_pixel(Q_MAX, Q_MAX, '0, PIXEL_LAST);
      queue_pixel(Q_MIN, Q_MIN, 12'd1, 12'd2);
      queue_pixel(Q_MIN, Q_MAX, 12'd2048, 12'd1024);
      queue_pixel(Q_QUARTER, Q_HALF, 12'd3, 12'd4);
      queue_pixel(-Q_THREE_QTR, Q_TENTH, 12'd5, 12'd6);
      queue_pixel(Q_CUSP, '0, 12'd7, 12'd8);               // slow escape near the cusp
      paint_staged();

      // zero iteration limit, upper bits of the write dropped
      write_reg(CSR_MAX_ITER, 32'h0001_0000);
      queue_pixel('0, '0, 12'd9, 12'd10);
      queue_pixel(-Q_TWO, '0, 12'd11, 12'd12);
      queue_pixel(Q_ONE, Q_HALF, 12'd13, 12'd14);
      paint_staged();

      // unused indexes, then julia with constant at the extremes
      for (int idx = FIRST_UNUSED_CSR; idx <= LAST_CSR_INDEX; idx++)
         write_reg(CSR_INDEX_BITS'(idx), '1);
      write_reg(CSR_FRACTAL_MODE, {30'h3FFF_FFFF, MODE_JULIA});
      write_reg(CSR_MAX_ITER, 32'd1);
      write_reg(CSR_CONST_REAL, Q_MIN);
      write_reg(CSR_CONST_IMAG, Q_MAX);
      queue_pixel('0, '0, 12'd15, 12'd16);
      queue_pixel(Q_ONE, Q_ONE, 12'd17, 12'd18);
      paint_staged();

      // burning ship, with the point and with a constant
      write_reg(CSR_FRACTAL_MODE, MODE_SHIP);
      write_reg(CSR_MAX_ITER, 32'd16);
      write_reg(CSR_CONST_REAL, Q_MAX);
      write_reg(CSR_CONST_IMAG, Q_MIN);
      queue_pixel(Q_SHIP_RE, Q_SHIP_IM, 12'd19, 12'd20);
      queue_pixel(Q_HALF, -Q_HALF, 12'd21, 12'd22);
      queue_pixel(-Q_HALF, Q_HALF, 12'd23, 12'd24);
      paint_staged();
      write_reg(CSR_FRACTAL_MODE, MODE_SHIP_CONST);
      write_reg(CSR_CONST_REAL, -Q_HALF);
      write_reg(CSR_CONST_IMAG, -Q_HALF);
      queue_pixel(Q_QUARTER, -Q_QUARTER, 12'd25, 12'd26);
      queue_pixel(-Q_ONE, Q_ONE, 12'd27, 12'd28);
      paint_staged();

      // largest limit, only a couple of pixels
      write_reg(CSR_FRACTAL_MODE, MODE_MANDELBROT);
      write_reg(CSR_MAX_ITER, '1);
      queue_pixel(-Q_TWO, '0, 12'd29, 12'd30);
      queue_pixel(Q_CUSP, '0, 12'd31, 12'd32);
      paint_staged();

      // random phases: mode, limit and constant drawn per phase
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         steady = ($urandom_range(0, 3) == 0);
         mode = 2'($urandom);
         sel = $urandom_range(0, 9);
         case (sel)
            0:       limit = ITER_BITS'(1);
            1:       limit = ITER_BITS'($urandom_range(2, 8));
            7, 8:    limit = ITER_BITS'($urandom_range(65, 200));
            9:       limit = ITER_BITS'(SHADE_SCALE);
            default: limit = ITER_BITS'($urandom_range(9, 64));
         endcase
         extra = $urandom;
         write_reg(CSR_FRACTAL_MODE, {extra[CSR_DATA_BITS-1:2], mode});
         extra = $urandom;
         write_reg(CSR_MAX_ITER, {extra[CSR_DATA_BITS-1:ITER_BITS], limit});
         write_reg(CSR_CONST_REAL,
                   ($urandom_range(0, 4) == 0) ? $urandom : rand_coord(Q_ONE));
         write_reg(CSR_CONST_IMAG,
                   ($urandom_range(0, 4) == 0) ? $urandom : rand_coord(Q_ONE));
         write_reg(CSR_INDEX_BITS'($urandom_range(FIRST_UNUSED_CSR, LAST_CSR_INDEX)),
                   $urandom);
         repeat (PHASE_PIXELS) queue_random_pixel();
         paint_staged();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (!mismatch_seen)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // watchdog
   initial begin
      #40_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

### files.f
hw/rtl/fet_pkg.sv
hw/rtl/fet_shade_div.sv
hw/rtl/fet_datapath.sv
hw/rtl/fet_ctrl.sv
hw/rtl/fractal_escape_time_unit.sv
hw/rtl/fet_checker.sv
bench/tb_fractal_escape_time_unit.sv
